### src/dstp_pkg.sv
package dstp_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned DigitsW   = 60;
  localparam int unsigned SigW      = 61;
  localparam int unsigned FracW     = 10;
  localparam int unsigned ExpValW   = 10;
  localparam int unsigned DecExpW   = 12;

  localparam logic [DigitsW-1:0] SigLimit  = 60'd999999999999999999;
  localparam logic [DigitsW-1:0] SigThresh = SigLimit / 60'd10;

  localparam logic [ExpValW-1:0] MaxExponent       = 10'd999;
  localparam logic [FracW-1:0]   MaxFractionDigits = 10'd1023;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0d;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChPlus  = 8'h2b;
  localparam logic [ChW-1:0] ChMinus = 8'h2d;
  localparam logic [ChW-1:0] ChDot   = 8'h2e;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChUpperE = 8'h45;
  localparam logic [ChW-1:0] ChLowerE = 8'h65;

  typedef struct packed {
    logic           vld;
    logic [ChW-1:0] ch;
  } item_t;

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_space(input logic [ChW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_exp_mark(input logic [ChW-1:0] c);
    return (c == ChLowerE) || (c == ChUpperE);
  endfunction

endpackage

### src/decimal_scientific_text_parser_core.sv
// decimal scientific text parser
// input channel: one character per transaction on ch_i (in_valid_i / in_stall_o);
// a zero character ends the string
// output channel: one transaction per terminator on significand_o,
// decimal_exponent_o and overflowed_o (out_valid_o / out_stall_i); the value is
// significand_o * 10^decimal_exponent_o
// non-terminator characters produce no output transaction
// an accepted terminator passes through the input register, then the result register
// throughput: one character per cycle, bar a terminator held by a stalled result;
// set by the combinational update of the parse state (multiply by ten and add)
// a stalled result is held in the result register while characters keep flowing;
// only a further terminator waits, stalling the input, until the result is taken
// reset: parse state returns to the leading whitespace phase, both registers empty

module decimal_scientific_text_parser_core
  import dstp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ChW-1:0]            ch_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SigW-1:0]    significand_o,
  output logic signed [DecExpW-1:0] decimal_exponent_o,
  output logic                      overflowed_o
);

  logic           vld_q;
  logic [ChW-1:0] ch_q;
  logic           take;
  item_t          item;

  assign item.vld   = vld_q;
  assign item.ch    = ch_q;
  assign in_stall_o = vld_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      vld_q <= 1'b1;
    end else if (take) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q <= ch_i;
    end
  end

  dstp_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (item),
    .take_o             (take),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .significand_o      (significand_o),
    .decimal_exponent_o (decimal_exponent_o),
    .overflowed_o       (overflowed_o)
  );

endmodule

### src/dstp_digit_acc.sv
module dstp_digit_acc
  import dstp_pkg::*;
(
  input  logic [DigitsW-1:0] acc_i,
  input  logic [3:0]         digit_i,
  output logic [DigitsW-1:0] acc_o,
  output logic               sat_o
);

  logic [DigitsW-1:0] times_ten;

  assign times_ten = (acc_i << 3) + (acc_i << 1);
  assign sat_o     = acc_i > SigThresh;
  assign acc_o     = sat_o ? SigLimit : times_ten + {{(DigitsW-4){1'b0}}, digit_i};

endmodule

### src/dstp_parser.sv
module dstp_parser
  import dstp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  item_t                     item_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SigW-1:0]    significand_o,
  output logic signed [DecExpW-1:0] decimal_exponent_o,
  output logic                      overflowed_o
);

  typedef enum logic [2:0] {
    PhLead,
    PhInt,
    PhFrac,
    PhExpSign,
    PhExpDig,
    PhStop
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 neg_q, neg_d;
  logic [DigitsW-1:0]   digits_q, digits_d;
  logic [FracW-1:0]     frac_q, frac_d;
  logic                 exp_neg_q, exp_neg_d;
  logic [ExpValW-1:0]   exp_q, exp_d;
  logic                 sat_q, sat_d;
  logic                 out_valid_q;
  logic [SigW-1:0]      sig_q, sig_d;
  logic [DecExpW-1:0]   dexp_q, dexp_d;
  logic                 ovf_q;

  logic                 is_nul;
  logic [3:0]           digit;
  logic [DigitsW-1:0]   acc_next;
  logic                 acc_sat;
  logic [13:0]          exp_next;
  logic                 exp_over;
  logic [ExpValW-1:0]   exp_sat_val;
  logic [DecExpW-1:0]   exp_signed;

  assign is_nul = item_i.ch == ChNul;
  assign take_o = item_i.vld && (!is_nul || !out_valid_q || !out_stall_i);
  assign digit  = 4'(item_i.ch - ChZero);

  dstp_digit_acc u_acc (
    .acc_i   (digits_q),
    .digit_i (digit),
    .acc_o   (acc_next),
    .sat_o   (acc_sat)
  );

  assign exp_next    = ({4'd0, exp_q} << 3) + ({4'd0, exp_q} << 1) + {10'd0, digit};
  assign exp_over    = exp_next > {4'd0, MaxExponent};
  assign exp_sat_val = exp_over ? MaxExponent : exp_next[ExpValW-1:0];

  assign exp_signed = exp_neg_q ? -{2'b00, exp_q} : {2'b00, exp_q};
  assign dexp_d     = exp_signed - {2'b00, frac_q};
  assign sig_d      = neg_q ? -{1'b0, digits_q} : {1'b0, digits_q};

  always_comb begin
    phase_d   = phase_q;
    neg_d     = neg_q;
    digits_d  = digits_q;
    frac_d    = frac_q;
    exp_neg_d = exp_neg_q;
    exp_d     = exp_q;
    sat_d     = sat_q;
    if (take_o) begin
      if (is_nul) begin
        phase_d   = PhLead;
        neg_d     = 1'b0;
        digits_d  = '0;
        frac_d    = '0;
        exp_neg_d = 1'b0;
        exp_d     = '0;
        sat_d     = 1'b0;
      end else begin
        case (phase_q)
          PhLead: begin
            if (is_space(item_i.ch)) begin
              phase_d = PhLead;
            end else if (item_i.ch == ChMinus) begin
              neg_d   = 1'b1;
              phase_d = PhInt;
            end else if (item_i.ch == ChPlus) begin
              phase_d = PhInt;
            end else if (is_digit(item_i.ch)) begin
              digits_d = acc_next;
              sat_d    = sat_q | acc_sat;
              phase_d  = PhInt;
            end else if (item_i.ch == ChDot) begin
              phase_d = PhFrac;
            end else if (is_exp_mark(item_i.ch)) begin
              phase_d = PhExpSign;
            end else begin
              phase_d = PhStop;
            end
          end
          PhInt: begin
            if (is_digit(item_i.ch)) begin
              digits_d = acc_next;
              sat_d    = sat_q | acc_sat;
            end else if (item_i.ch == ChDot) begin
              phase_d = PhFrac;
            end else if (is_exp_mark(item_i.ch)) begin
              phase_d = PhExpSign;
            end else begin
              phase_d = PhStop;
            end
          end
          PhFrac: begin
            if (is_digit(item_i.ch)) begin
              digits_d = acc_next;
              if (frac_q >= MaxFractionDigits) begin
                sat_d = 1'b1;
              end else begin
                frac_d = frac_q + FracW'(1);
                sat_d  = sat_q | acc_sat;
              end
            end else if (is_exp_mark(item_i.ch)) begin
              phase_d = PhExpSign;
            end else begin
              phase_d = PhStop;
            end
          end
          PhExpSign: begin
            if (item_i.ch == ChMinus) begin
              exp_neg_d = 1'b1;
              phase_d   = PhExpDig;
            end else if (item_i.ch == ChPlus) begin
              phase_d = PhExpDig;
            end else if (is_digit(item_i.ch)) begin
              exp_d   = exp_sat_val;
              sat_d   = sat_q | exp_over;
              phase_d = PhExpDig;
            end else begin
              phase_d = PhStop;
            end
          end
          PhExpDig: begin
            if (is_digit(item_i.ch)) begin
              exp_d = exp_sat_val;
              sat_d = sat_q | exp_over;
            end else begin
              phase_d = PhStop;
            end
          end
          default: begin
            phase_d = PhStop;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      neg_q       <= 1'b0;
      digits_q    <= '0;
      frac_q      <= '0;
      exp_neg_q   <= 1'b0;
      exp_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      neg_q     <= neg_d;
      digits_q  <= digits_d;
      frac_q    <= frac_d;
      exp_neg_q <= exp_neg_d;
      exp_q     <= exp_d;
      sat_q     <= sat_d;
      if (take_o && is_nul) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && is_nul) begin
      sig_q  <= sig_d;
      dexp_q <= dexp_d;
      ovf_q  <= sat_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign significand_o      = sig_q;
  assign decimal_exponent_o = dexp_q;
  assign overflowed_o       = ovf_q;

`ifndef ASSERT_OFF
  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= SigLimit) else $error("significand above limit");

  a_exp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q <= MaxExponent) else $error("exponent above limit");

  a_nul_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && is_nul |=> out_valid_q && phase_q == PhLead && digits_q == '0 && !sat_q)
    else $error("terminator did not emit and clear");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(take_o && is_nul))
    else $error("result overwritten while stalled");
`endif

endmodule
